// ----- hdl/peer_table_with_staleness_assert.svh -----
// Assertion helpers for the peer table. Each check runs on the rising clock
// edge and is switched off while reset is high.
`ifndef PEER_TABLE_WITH_STALENESS_ASSERT_SVH
`define PEER_TABLE_WITH_STALENESS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTWS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ptws_pkg.sv -----
`default_nettype none
package ptws_pkg;

   localparam int TABLE_DEPTH_DEF = 16;

   localparam int ADDR_W      = 48;
   localparam int TIME_W      = 32;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 48;

   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SEEN   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_DONE    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_PRESENT = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_OWN     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_MISSING = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALE_LIMIT = 1'b1;

   localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET = 48'd0;
   localparam logic [TIME_W-1:0] STALE_LIMIT_RESET = 32'd10000;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] peer_address;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic                in_range;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [TIME_W-1:0] last_seen;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_MOVE,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic start;
      logic search;
      logic decide;
      logic read_last;
      logic write_add;
      logic write_move;
      logic write_seen;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              hit;
      logic              exhausted;
      logic              found;
      logic              own;
      logic              full;
      logic              rsp_free;
   } stat_type;

endpackage
`default_nettype wire

// ----- hdl/ptws_dpath.sv -----
`default_nettype none
module ptws_dpath #(
   parameter int TABLE_DEPTH = ptws_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ptws_pkg::req_type                req_payload,
   output ptws_pkg::rsp_type                     rsp_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic                             csr_wr_en,
   input  wire logic [ptws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ptws_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire ptws_pkg::cmd_type                cmd,
   output ptws_pkg::stat_type                    stat
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   ptws_pkg::entry_type mem [TABLE_DEPTH];

   ptws_pkg::req_type   req_ff;
   ptws_pkg::rsp_type   rsp_ff;
   ptws_pkg::entry_type rd_data_ff;
   ptws_pkg::entry_type wr_data;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [CNT_W-1:0]    idx_ff;
   logic [CNT_W-1:0]    idx_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [CNT_W-1:0]    last_idx;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic [IDX_W-1:0]    slot_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic                wr_en;
   logic                rd_vld_ff;
   logic                issue;
   logic                match;
   logic                found_ff;
   logic [ptws_pkg::TIME_W-1:0] ts_ff;
   logic [ptws_pkg::TIME_W-1:0] age;
   logic [ptws_pkg::ADDR_W-1:0] own_ff;
   logic [ptws_pkg::TIME_W-1:0] limit_ff;
   logic [ptws_pkg::STATUS_W-1:0] status_ff;
   logic [ptws_pkg::STATUS_W-1:0] status_in;
   logic                in_range_ff;
   logic                in_range_in;
   logic                own;
   logic                full;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff   <= ptws_pkg::OWN_ADDRESS_RESET;
         limit_ff <= ptws_pkg::STALE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ptws_pkg::CSR_OWN_ADDRESS: own_ff   <= csr_wdata;
            ptws_pkg::CSR_STALE_LIMIT: limit_ff <= csr_wdata[ptws_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff <= req_payload;
      end
   end

   // Search walks slots below the live count, one read issued per cycle.
   // Read data is registered, so each compare comes in the cycle after its address.
   assign issue    = cmd.search && (idx_ff < count_ff);
   assign match    = rd_vld_ff && (rd_data_ff.address == req_ff.peer_address);
   assign last_idx = count_ff - CNT_W'(1);
   assign rd_addr  = cmd.read_last ? last_idx[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   always_comb begin
      idx_in = idx_ff;
      if (cmd.start) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         rd_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_idx_ff <= idx_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.start) begin
         found_ff <= 1'b0;
      end else if (cmd.search && match) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search && match) begin
         slot_ff <= rd_idx_ff;
         ts_ff   <= rd_data_ff.last_seen;
      end
   end

   // Table memory: one write port, one registered read port.
   always_comb begin
      wr_en   = cmd.write_add || cmd.write_move || cmd.write_seen;
      wr_addr = cmd.write_add ? count_ff[IDX_W-1:0] : slot_ff;
      if (cmd.write_move) begin
         wr_data = rd_data_ff;
      end else begin
         wr_data.address   = req_ff.peer_address;
         wr_data.last_seen = req_ff.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.write_add) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.write_move) begin
         count_in = last_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign own  = (req_ff.peer_address == own_ff);
   assign full = (count_ff >= DEPTH_CNT);
   assign age  = req_ff.now_ms - ts_ff;

   always_comb begin
      status_in   = ptws_pkg::STAT_DONE;
      in_range_in = 1'b0;
      case (req_ff.mode)
         ptws_pkg::MODE_QUERY: begin
            if (found_ff) begin
               in_range_in = (age < limit_ff);
            end else begin
               status_in = ptws_pkg::STAT_MISSING;
            end
         end
         ptws_pkg::MODE_ADD: begin
            if (found_ff) begin
               status_in = ptws_pkg::STAT_PRESENT;
            end else if (own) begin
               status_in = ptws_pkg::STAT_OWN;
            end else if (full) begin
               status_in = ptws_pkg::STAT_FULL;
            end
         end
         ptws_pkg::MODE_REMOVE: begin
            if (!found_ff) begin
               status_in = ptws_pkg::STAT_MISSING;
            end
         end
         default: begin
            if (own) begin
               status_in = ptws_pkg::STAT_OWN;
            end else if (!found_ff) begin
               status_in = ptws_pkg::STAT_MISSING;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         status_ff   <= status_in;
         in_range_ff <= in_range_in;
      end
   end

   // Output register; the count is sampled after any table update.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.found       <= found_ff;
         rsp_ff.in_range    <= in_range_ff;
         rsp_ff.entry_count <= ptws_pkg::COUNT_W'(count_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_payload = rsp_ff;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      stat.mode      = req_ff.mode;
      stat.hit       = match;
      stat.exhausted = !rd_vld_ff && (idx_ff >= count_ff);
      stat.found     = found_ff;
      stat.own       = own;
      stat.full      = full;
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule
`default_nettype wire

// ----- hdl/ptws_ctrl.sv -----
`default_nettype none
module ptws_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire ptws_pkg::stat_type stat,
   output ptws_pkg::cmd_type       cmd
);

   ptws_pkg::state_type state_ff;
   ptws_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptws_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptws_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = ptws_pkg::S_SEARCH;
            end
         end
         ptws_pkg::S_SEARCH: begin
            if (stat.hit || stat.exhausted) begin
               state_in = ptws_pkg::S_DECIDE;
            end
         end
         ptws_pkg::S_DECIDE: begin
            if (stat.mode == ptws_pkg::MODE_REMOVE && stat.found) begin
               state_in = ptws_pkg::S_MOVE;
            end else begin
               state_in = ptws_pkg::S_RESPOND;
            end
         end
         ptws_pkg::S_MOVE: begin
            state_in = ptws_pkg::S_RESPOND;
         end
         ptws_pkg::S_RESPOND: begin
            if (stat.rsp_free) begin
               state_in = ptws_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ptws_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ptws_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ptws_pkg::S_SEARCH: begin
            cmd.search = 1'b1;
         end
         ptws_pkg::S_DECIDE: begin
            cmd.decide = 1'b1;
            case (stat.mode)
               ptws_pkg::MODE_ADD: begin
                  cmd.write_add = !stat.found && !stat.own && !stat.full;
               end
               ptws_pkg::MODE_REMOVE: begin
                  // Fetch the last entry so it can fill the freed slot.
                  cmd.read_last = stat.found;
               end
               ptws_pkg::MODE_SEEN: begin
                  cmd.write_seen = stat.found && !stat.own;
               end
               default: ;
            endcase
         end
         ptws_pkg::S_MOVE: begin
            cmd.write_move = 1'b1;
         end
         ptws_pkg::S_RESPOND: begin
            cmd.load_rsp = stat.rsp_free;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ----- hdl/peer_table_with_staleness.sv -----
`default_nettype none
// Peer table with staleness: holds up to TABLE_DEPTH 48-bit peer addresses
// with last-seen timestamps and answers query, add, remove and seen requests,
// one request at a time, each returning one response beat. An accepted
// request passes through a search, a decide step and, for a successful
// remove, a move step that copies the last entry into the freed slot, before
// the response register is loaded. The linear search visits the slots up to
// and including the match on a hit and every live slot on a miss; it reads
// one table slot per cycle through a registered read port, so each compare
// comes in the cycle after its address. A new request is taken in the cycle
// after the previous response has been loaded into the output register, and
// a response may wait there while the next request is accepted; loading the
// next response then waits until that beat has left. Configuration writes
// (own address, stale limit) must be made while no request is in flight. No
// clearing pass runs after reset: the table starts empty.
`include "peer_table_with_staleness_assert.svh"
module peer_table_with_staleness #(
   parameter int TABLE_DEPTH = ptws_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire ptws_pkg::req_type                req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output ptws_pkg::rsp_type                     rsp_payload,
   input  wire logic                             csr_wr_en,
   input  wire logic [ptws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ptws_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ptws_pkg::cmd_type  cmd;
   ptws_pkg::stat_type stat;

   ptws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptws_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat)
   );

   `PTWS_ASSERT_SAME(a_add_not_full, cmd.write_add, !stat.full,
      "add written into a full table")
   `PTWS_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready,
      "second request accepted while one is in flight")
   `PTWS_ASSERT_SAME(a_in_range_found, rsp_valid && rsp_payload.in_range,
      rsp_payload.found && rsp_payload.status == ptws_pkg::STAT_DONE,
      "in-range response without a found entry")
   `PTWS_ASSERT_SAME(a_write_one_hot, 1'b1,
      $onehot0({cmd.write_add, cmd.write_move, cmd.write_seen}),
      "more than one table write in a cycle")

endmodule
`default_nettype wire

// ----- test/peer_table_monitor.sv -----
`timescale 1ns / 100ps
module peer_table_monitor
   import ptws_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     pending_responses
);

   logic [ADDR_W-1:0] peer_address [TABLE_DEPTH];
   logic [TIME_W-1:0] peer_last_seen [TABLE_DEPTH];
   int                peer_count;
   logic [ADDR_W-1:0] own_address;
   logic [TIME_W-1:0] stale_limit;
   rsp_type           predicted_responses [$];
   int                fail_tally;

   // Applies one operation to the shadow table and returns the response it should produce.
   function automatic rsp_type apply_peer_op(input req_type op);
      rsp_type           result;
      int                slot;
      int                i;
      logic              hit;
      logic [TIME_W-1:0] age;
      hit = 1'b0;
      slot = 0;
      for (i = 0; i < peer_count; i++) begin
         if (!hit && peer_address[i] == op.peer_address) begin
            hit = 1'b1;
            slot = i;
         end
      end
      result = '0;
      result.found = hit;
      result.status = STAT_DONE;
      case (op.mode)
         MODE_QUERY: begin
            if (hit) begin
               age = op.now_ms - peer_last_seen[slot];
               result.in_range = age < stale_limit;
            end else begin
               result.status = STAT_MISSING;
            end
         end
         MODE_ADD: begin
            if (hit) begin
               result.status = STAT_PRESENT;
            end else if (op.peer_address == own_address) begin
               result.status = STAT_OWN;
            end else if (peer_count >= TABLE_DEPTH) begin
               result.status = STAT_FULL;
            end else begin
               peer_address[peer_count] = op.peer_address;
               peer_last_seen[peer_count] = op.now_ms;
               peer_count++;
            end
         end
         MODE_REMOVE: begin
            // The last live entry fills the hole so the table stays packed.
            if (hit) begin
               peer_address[slot] = peer_address[peer_count - 1];
               peer_last_seen[slot] = peer_last_seen[peer_count - 1];
               peer_count--;
            end else begin
               result.status = STAT_MISSING;
            end
         end
         MODE_SEEN: begin
            if (op.peer_address == own_address) begin
               result.status = STAT_OWN;
            end else if (hit) begin
               peer_last_seen[slot] = op.now_ms;
            end else begin
               result.status = STAT_MISSING;
            end
         end
      endcase
      result.entry_count = COUNT_W'(peer_count);
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         peer_count = 0;
         own_address = OWN_ADDRESS_RESET;
         stale_limit = STALE_LIMIT_RESET;
         predicted_responses.delete();
         fail_tally = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_OWN_ADDRESS: own_address = csr_wdata[ADDR_W-1:0];
               CSR_STALE_LIMIT: stale_limit = csr_wdata[TIME_W-1:0];
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_responses.size() == 0) begin
               $display("%0t: response beat with nothing expected, got %p", $time, rsp_payload);
               fail_tally++;
            end else begin
               want = predicted_responses.pop_front();
               if (rsp_payload.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_payload.status);
                  fail_tally++;
               end
               if (rsp_payload.found !== want.found) begin
                  $display("%0t: found expected %0d, got %0d",
                           $time, want.found, rsp_payload.found);
                  fail_tally++;
               end
               if (rsp_payload.in_range !== want.in_range) begin
                  $display("%0t: in_range expected %0d, got %0d",
                           $time, want.in_range, rsp_payload.in_range);
                  fail_tally++;
               end
               if (rsp_payload.entry_count !== want.entry_count) begin
                  $display("%0t: entry_count expected %0d, got %0d",
                           $time, want.entry_count, rsp_payload.entry_count);
                  fail_tally++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted_responses.push_back(apply_peer_op(req_payload));
         end
      end
      mismatch_count <= fail_tally;
      pending_responses <= predicted_responses.size();
   end

endmodule

// ----- test/peer_table_with_staleness_tb.sv -----
`timescale 1ns / 100ps
module peer_table_with_staleness_tb;
   import ptws_pkg::*;

   localparam int          POOL_SIZE      = 24;
   localparam int          RANDOM_PHASES  = 8;
   localparam int          PHASE_REQUESTS = 56;
   localparam int unsigned TIMEOUT_NS     = 6_000_000;
   localparam logic [ADDR_W-1:0] ALL_ONES_ADDR = '1;
   localparam logic [TIME_W-1:0] WRAP_START    = 32'hFFFF_FFF0;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_payload;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     mismatch_count;
   int                     pending_responses;

   logic [ADDR_W-1:0] peer_pool [POOL_SIZE];
   logic [TIME_W-1:0] clock_ms;
   bit                req_gaps_off;
   bit                rsp_stall_off;
   int                requests_sent;
   int                settings_written;

   always #6 clock = ~clock;

   peer_table_with_staleness i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   peer_table_monitor i_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload       (rsp_payload),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .pending_responses (pending_responses)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return wide[ADDR_W-1:0];
   endfunction

   // Most beats work on a small address pool so that hits, refreshes and a full table
   // all occur; the rest are arbitrary beats.
   function automatic req_type random_request(input int add_weight);
      req_type item;
      int      roll;
      if ($urandom_range(0, 99) < 80) begin
         roll = $urandom_range(0, 99);
         if (roll < add_weight) item.mode = MODE_ADD;
         else if (roll < add_weight + 25) item.mode = MODE_QUERY;
         else if (roll < add_weight + 45) item.mode = MODE_SEEN;
         else item.mode = MODE_REMOVE;
         item.peer_address = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
         if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
         else clock_ms = clock_ms + $urandom_range(0, 3000);
         item.now_ms = clock_ms;
      end else begin
         item.mode = MODE_W'($urandom_range(0, 3));
         item.peer_address = rand_addr();
         item.now_ms = $urandom;
      end
      return item;
   endfunction

   task automatic send_request(input logic [MODE_W-1:0] op_mode,
                               input logic [ADDR_W-1:0] address,
                               input logic [TIME_W-1:0] stamp);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= '{op_mode, address, stamp};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      gap = req_gaps_off ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Stops the request stream and waits until every response beat is back.
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_responses != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure_phase(input int phase);
      logic [ADDR_W-1:0] own;
      logic [TIME_W-1:0] limit;
      case (phase % 5)
         0: begin
            own = peer_pool[$urandom_range(2, POOL_SIZE - 1)];
            limit = 32'hFFFF_FFFF;
         end
         1: begin
            own = '0;
            limit = 32'd1500;
         end
         2: begin
            own = ALL_ONES_ADDR;
            limit = '0;
         end
         3: begin
            own = rand_addr();
            limit = $urandom;
         end
         default: begin
            own = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
            limit = STALE_LIMIT_RESET;
         end
      endcase
      write_register(CSR_OWN_ADDRESS, own);
      write_register(CSR_STALE_LIMIT, CSR_DATA_W'(limit));
      settings_written++;
   endtask

   initial begin : rsp_backpressure
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_off) begin
            rsp_ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
         end else if (rsp_ready) begin
            hold = pick_gap();
            if (hold > 0) begin
               rsp_ready <= 1'b0;
               hold--;
            end else begin
               hold = $urandom_range(0, 6);
            end
         end else begin
            rsp_ready <= 1'b1;
            hold = $urandom_range(0, 8);
         end
      end
   end

   initial begin : stimulus
      req_type item;
      int      phase;
      int      i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_gaps_off = 1'b0;
      rsp_stall_off = 1'b0;
      requests_sent = 0;
      settings_written = 0;
      clock_ms = $urandom;
      peer_pool[0] = '0;
      peer_pool[1] = ALL_ONES_ADDR;
      for (i = 2; i < POOL_SIZE; i++) peer_pool[i] = rand_addr();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Empty table under reset settings: the own address is zero.
      send_request(MODE_QUERY, peer_pool[0], 32'd0);
      send_request(MODE_REMOVE, peer_pool[1], 32'd1);
      send_request(MODE_SEEN, peer_pool[1], 32'd2);
      send_request(MODE_ADD, peer_pool[0], 32'd3);
      send_request(MODE_ADD, peer_pool[1], WRAP_START);
      send_request(MODE_ADD, peer_pool[1], WRAP_START);
      // Age across the 32-bit wrap, then an age exactly equal to the limit.
      send_request(MODE_QUERY, peer_pool[1], 32'h0000_0010);
      send_request(MODE_QUERY, peer_pool[1], WRAP_START + STALE_LIMIT_RESET);
      send_request(MODE_SEEN, peer_pool[1], 32'h0000_5000);
      for (i = 2; i <= 16; i++) send_request(MODE_ADD, peer_pool[i], 32'h0000_5000 + i);
      send_request(MODE_ADD, peer_pool[17], 32'h0000_6000);
      send_request(MODE_ADD, peer_pool[0], 32'h0000_6001);
      send_request(MODE_REMOVE, peer_pool[5], 32'h0000_6002);
      send_request(MODE_QUERY, peer_pool[16], 32'h0000_6003);
      drain_block();

      // Own address that already sits in the table, with a zero stale limit.
      write_register(CSR_OWN_ADDRESS, peer_pool[3]);
      write_register(CSR_STALE_LIMIT, '0);
      settings_written++;
      send_request(MODE_SEEN, peer_pool[3], 32'h0000_7000);
      send_request(MODE_ADD, peer_pool[3], 32'h0000_7001);
      send_request(MODE_QUERY, peer_pool[3], 32'h0000_5003);
      send_request(MODE_REMOVE, peer_pool[3], 32'h0000_7002);
      drain_block();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure_phase(phase);
         req_gaps_off = (phase == 1) || ($urandom_range(0, 3) == 0);
         rsp_stall_off = (phase == 1) || ($urandom_range(0, 3) == 0);
         for (i = 0; i < PHASE_REQUESTS; i++) begin
            item = random_request((phase % 2) ? 45 : 20);
            send_request(item.mode, item.peer_address, item.now_ms);
         end
         drain_block();
      end

      repeat (40) @(posedge clock);
      $display("Covered %0d requests under %0d register settings: corner cases, then pool traffic",
               requests_sent, settings_written);
      $display("with a full table, wrapped timestamps and random stalls on both channels.");
      if (mismatch_count == 0 && pending_responses == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("%0t: run did not complete, %0d responses outstanding", $time, pending_responses);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
